[rtl/rms_pkg.sv]
// Shared types, codes and helpers for the robot mode supervisor.
package rms_pkg;

    // Mode register, one-hot
    typedef enum logic [10:0] {
        MODE_DISC    = 11'b000_0000_0001,
        MODE_IDLE    = 11'b000_0000_0010,
        MODE_MOVING  = 11'b000_0000_0100,
        MODE_SPEED   = 11'b000_0000_1000,
        MODE_SERVO   = 11'b000_0001_0000,
        MODE_FREE    = 11'b000_0010_0000,
        MODE_FORCE   = 11'b000_0100_0000,
        MODE_IMPED   = 11'b000_1000_0000,
        MODE_PAUSED  = 11'b001_0000_0000,
        MODE_ERROR   = 11'b010_0000_0000,
        MODE_RESCUE  = 11'b100_0000_0000
    } t_mode;

    // External mode codes
    localparam logic [3:0] CODE_DISC   = 4'd0;
    localparam logic [3:0] CODE_IDLE   = 4'd1;
    localparam logic [3:0] CODE_MOVING = 4'd2;
    localparam logic [3:0] CODE_SPEED  = 4'd3;
    localparam logic [3:0] CODE_SERVO  = 4'd4;
    localparam logic [3:0] CODE_FREE   = 4'd5;
    localparam logic [3:0] CODE_FORCE  = 4'd6;
    localparam logic [3:0] CODE_IMPED  = 4'd7;
    localparam logic [3:0] CODE_PAUSED = 4'd8;
    localparam logic [3:0] CODE_ERROR  = 4'd9;
    localparam logic [3:0] CODE_RESCUE = 4'd10;
    localparam logic [3:0] CODE_LAST   = CODE_RESCUE;

    // Commands
    localparam logic [1:0] CMD_APPLY = 2'd0;
    localparam logic [1:0] CMD_FORCE = 2'd1;
    localparam logic [1:0] CMD_PROBE = 2'd2;

    // Events
    localparam logic [4:0] EV_CONN      = 5'd0;
    localparam logic [4:0] EV_DISC      = 5'd1;
    localparam logic [4:0] EV_MOVE      = 5'd2;
    localparam logic [4:0] EV_SPEED     = 5'd3;
    localparam logic [4:0] EV_SERVO     = 5'd4;
    localparam logic [4:0] EV_FREE_ON   = 5'd5;
    localparam logic [4:0] EV_FREE_OFF  = 5'd6;
    localparam logic [4:0] EV_FORCE_IN  = 5'd7;
    localparam logic [4:0] EV_FORCE_OUT = 5'd8;
    localparam logic [4:0] EV_IMP_IN    = 5'd9;
    localparam logic [4:0] EV_IMP_OUT   = 5'd10;
    localparam logic [4:0] EV_DONE      = 5'd11;
    localparam logic [4:0] EV_PAUSE     = 5'd12;
    localparam logic [4:0] EV_RESUME    = 5'd13;
    localparam logic [4:0] EV_STOP      = 5'd14;
    localparam logic [4:0] EV_ERROR     = 5'd15;
    localparam logic [4:0] EV_CLEAR     = 5'd16;
    localparam logic [4:0] EV_RESC_IN   = 5'd17;
    localparam logic [4:0] EV_RESC_OUT  = 5'd18;

    // Motion-conflict reasons
    localparam logic [1:0] CONF_NOT_CONN = 2'd0;
    localparam logic [1:0] CONF_FREE     = 2'd1;
    localparam logic [1:0] CONF_FATAL    = 2'd2;
    localparam logic [1:0] CONF_CALLING  = 2'd3;

    // Configuration register indexes
    localparam logic REG_INITIAL_STATE = 1'b0;

    // One result word
    typedef struct packed {
        logic [3:0] old_state;
        logic [3:0] new_state;
        logic       changed;
        logic       connected;
        logic       idle_ready;
        logic       moving;
        logic       in_error;
        logic [1:0] conflict_code;
    } t_result;

    // Map a code at most CODE_LAST to its one-hot mode
    function automatic t_mode code_to_mode(input logic [3:0] code);
        t_mode m;
        unique case (code)
            CODE_DISC:   m = MODE_DISC;
            CODE_IDLE:   m = MODE_IDLE;
            CODE_MOVING: m = MODE_MOVING;
            CODE_SPEED:  m = MODE_SPEED;
            CODE_SERVO:  m = MODE_SERVO;
            CODE_FREE:   m = MODE_FREE;
            CODE_FORCE:  m = MODE_FORCE;
            CODE_IMPED:  m = MODE_IMPED;
            CODE_PAUSED: m = MODE_PAUSED;
            CODE_ERROR:  m = MODE_ERROR;
            CODE_RESCUE: m = MODE_RESCUE;
            default:     m = MODE_DISC;
        endcase
        return m;
    endfunction

    // Map a one-hot mode to its code
    function automatic logic [3:0] mode_to_code(input t_mode m);
        logic [3:0] c;
        unique case (m)
            MODE_DISC:   c = CODE_DISC;
            MODE_IDLE:   c = CODE_IDLE;
            MODE_MOVING: c = CODE_MOVING;
            MODE_SPEED:  c = CODE_SPEED;
            MODE_SERVO:  c = CODE_SERVO;
            MODE_FREE:   c = CODE_FREE;
            MODE_FORCE:  c = CODE_FORCE;
            MODE_IMPED:  c = CODE_IMPED;
            MODE_PAUSED: c = CODE_PAUSED;
            MODE_ERROR:  c = CODE_ERROR;
            MODE_RESCUE: c = CODE_RESCUE;
            default:     c = CODE_DISC;
        endcase
        return c;
    endfunction

endpackage

[rtl/rms_next.sv]
// Mode transition rules and result word formation for one command.
module rms_next (
    input  rms_pkg::t_mode   i_cur,
    input  logic [1:0]       i_cmd,
    input  logic [4:0]       i_event_code,
    input  logic [3:0]       i_force_value,
    output rms_pkg::t_mode   o_next,
    output rms_pkg::t_result o_result
);
    import rms_pkg::*;

    t_mode ev_target;
    t_mode target;
    t_mode after;

    // Resolve the event against the current mode
    always_comb begin
        ev_target = i_cur;
        if (i_event_code == EV_ERROR && i_cur != MODE_DISC) begin
            ev_target = MODE_ERROR;
        end else if (i_event_code == EV_DISC) begin
            ev_target = MODE_DISC;
        end else begin
            unique case (i_cur)
                MODE_DISC: begin
                    if (i_event_code == EV_CONN) ev_target = MODE_IDLE;
                end
                MODE_IDLE: begin
                    case (i_event_code)
                        EV_MOVE:     ev_target = MODE_MOVING;
                        EV_SPEED:    ev_target = MODE_SPEED;
                        EV_SERVO:    ev_target = MODE_SERVO;
                        EV_FREE_ON:  ev_target = MODE_FREE;
                        EV_FORCE_IN: ev_target = MODE_FORCE;
                        EV_IMP_IN:   ev_target = MODE_IMPED;
                        EV_RESC_IN:  ev_target = MODE_RESCUE;
                        default:     ev_target = i_cur;
                    endcase
                end
                MODE_MOVING: begin
                    if (i_event_code == EV_DONE || i_event_code == EV_STOP) begin
                        ev_target = MODE_IDLE;
                    end else if (i_event_code == EV_PAUSE) begin
                        ev_target = MODE_PAUSED;
                    end
                end
                MODE_PAUSED: begin
                    if (i_event_code == EV_RESUME) begin
                        ev_target = MODE_MOVING;
                    end else if (i_event_code == EV_STOP) begin
                        ev_target = MODE_IDLE;
                    end
                end
                MODE_SPEED, MODE_SERVO: begin
                    if (i_event_code == EV_STOP) ev_target = MODE_IDLE;
                end
                MODE_FREE: begin
                    if (i_event_code == EV_FREE_OFF) ev_target = MODE_IDLE;
                end
                MODE_FORCE: begin
                    if (i_event_code == EV_FORCE_OUT) ev_target = MODE_IDLE;
                end
                MODE_IMPED: begin
                    if (i_event_code == EV_IMP_OUT) ev_target = MODE_IDLE;
                end
                MODE_ERROR: begin
                    if (i_event_code == EV_CLEAR) ev_target = MODE_IDLE;
                end
                MODE_RESCUE: begin
                    if (i_event_code == EV_RESC_OUT) ev_target = MODE_IDLE;
                end
                default: ev_target = i_cur;
            endcase
        end
    end

    // Pick target and committed mode by command; unknown command probes
    always_comb begin
        case (i_cmd)
            CMD_APPLY: begin
                target = ev_target;
                after  = ev_target;
            end
            CMD_FORCE: begin
                target = (i_force_value <= CODE_LAST) ? code_to_mode(i_force_value) : i_cur;
                after  = target;
            end
            default: begin
                target = ev_target;
                after  = i_cur;
            end
        endcase
    end

    assign o_next = after;

    // Result word: states from current and target mode, flags from committed mode
    always_comb begin
        o_result.old_state  = mode_to_code(i_cur);
        o_result.new_state  = mode_to_code(target);
        o_result.changed    = (target != i_cur);
        o_result.connected  = (after != MODE_DISC);
        o_result.idle_ready = (after == MODE_IDLE);
        o_result.moving     = (after == MODE_MOVING) || (after == MODE_SPEED)
                              || (after == MODE_SERVO);
        o_result.in_error   = (after == MODE_ERROR);
        case (after)
            MODE_DISC:  o_result.conflict_code = CONF_NOT_CONN;
            MODE_FREE:  o_result.conflict_code = CONF_FREE;
            MODE_ERROR: o_result.conflict_code = CONF_FATAL;
            default:    o_result.conflict_code = CONF_CALLING;
        endcase
    end

endmodule

[rtl/robot_mode_supervisor_top.sv]
// Robot mode supervisor top level: mode register, result register, APB port.
// Each result word is registered and appears the cycle after its command is taken.
// Throughput: one word per cycle while the result channel does not stall; the mode
// register feeds back through the combinational transition table, and the result
// register frees as it is taken. Reset (synchronous, active low) clears the mode to
// Disconnected, the initial_state register to 0 and the result register to empty.
module robot_mode_supervisor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [4:0]  i_event_code,
    input  logic [3:0]  i_force_value,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_old_state,
    output logic [3:0]  o_new_state,
    output logic        o_changed,
    output logic        o_connected,
    output logic        o_idle_ready,
    output logic        o_moving,
    output logic        o_in_error,
    output logic [1:0]  o_conflict_code,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rms_pkg::*;

    t_mode   r_mode;
    t_mode   n_mode;
    logic [3:0] r_init;
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;
    logic    in_acc;
    logic    cfg_wr;
    logic    reg_sel;

    // Transition logic
    rms_next u_next (
        .i_cur         (r_mode),
        .i_cmd         (i_cmd),
        .i_event_code  (i_event_code),
        .i_force_value (i_force_value),
        .o_next        (n_mode),
        .o_result      (n_out)
    );

    // Handshakes
    assign o_stall = r_out_valid & i_stall;
    assign in_acc  = i_valid & ~o_stall;
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_INITIAL_STATE);
    assign cfg_wr  = psel & penable & pwrite & pready;

    // Read back the register
    assign prdata = reg_sel ? {28'd0, r_init} : 32'd0;

    // Mode and initial_state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_DISC;
            r_init <= CODE_DISC;
        end else if (cfg_wr && reg_sel) begin
            r_init <= pwdata[3:0];
            if (pwdata[3:0] <= CODE_LAST) r_mode <= code_to_mode(pwdata[3:0]);
        end else if (in_acc) begin
            r_mode <= n_mode;
        end
    end

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload: load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= n_out;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_old_state     = r_out.old_state;
    assign o_new_state     = r_out.new_state;
    assign o_changed       = r_out.changed;
    assign o_connected     = r_out.connected;
    assign o_idle_ready    = r_out.idle_ready;
    assign o_moving        = r_out.moving;
    assign o_in_error      = r_out.in_error;
    assign o_conflict_code = r_out.conflict_code;

    // Mode register stays one-hot
    a_mode_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_mode))
        else $error("mode register not one-hot");

    // Applied or forced word leaves the mode at its reported new state
    a_commit_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !cfg_wr && !i_cmd[1]) |=> (o_new_state == mode_to_code(r_mode)))
        else $error("committed mode differs from reported new state");

    // Probe leaves the mode untouched
    a_probe_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !cfg_wr && i_cmd[1]) |=> (r_mode == $past(r_mode)))
        else $error("probe changed the mode");

    // Changed flag agrees with the reported states
    a_changed_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_changed == (o_old_state != o_new_state)))
        else $error("changed flag inconsistent");

endmodule
